@@ hdl/sgi_pkg.sv @@
// Shared widths, latencies, payload types and the no-point value for the segment intersection.
package sgi_pkg;

  localparam int COORD_FRAC_BITS = 16;

  localparam int CW   = 32;
  localparam int TOLW = 16;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int WW   = PW + 1;
  localparam int SPL  = 34;
  localparam int TW   = DW + WW + 1;
  localparam int QB   = 34;

  localparam int SLW = (DW + COORD_FRAC_BITS > TOLW + DW) ? DW + COORD_FRAC_BITS : TOLW + DW;
  localparam int PLW = (WW + COORD_FRAC_BITS > TOLW + PW) ? WW + COORD_FRAC_BITS : TOLW + PW;

  localparam int FRONT_LAT = 4;
  localparam int RES_LAT   = 4 + QB + 2;
  localparam int PIPE_LAT  = FRONT_LAT + RES_LAT;

  localparam longint SENT_RAW = -(64'sd9999 <<< COORD_FRAC_BITS);
  localparam logic [CW-1:0] SENTINEL = (SENT_RAW < -64'sd2147483648) ?
                                       32'h8000_0000 : CW'(SENT_RAW);

  typedef struct packed {
    logic signed [CW-1:0] seg1_x_start;
    logic signed [CW-1:0] seg1_y_start;
    logic signed [CW-1:0] seg1_x_end;
    logic signed [CW-1:0] seg1_y_end;
    logic signed [CW-1:0] seg2_x_start;
    logic signed [CW-1:0] seg2_y_start;
    logic signed [CW-1:0] seg2_x_end;
    logic signed [CW-1:0] seg2_y_end;
  } seg_t;

  typedef struct packed {
    logic                 compute;
    logic [CW-1:0]        direct;
    logic signed [CW-1:0] base;
    logic signed [DW-1:0] p;
    logic signed [WW-1:0] q;
    logic signed [WW-1:0] den;
  } job_t;

  typedef struct packed {
    logic [CW-1:0] value;
    logic          ovf;
  } res_t;

endpackage

@@ hdl/sgi_front.sv @@
// Front pipeline: differences, cross products, case decision and operand selection.
module sgi_front (
  input  logic                        clk,
  input  logic                        en,
  input  sgi_pkg::seg_t               seg,
  input  logic [sgi_pkg::TOLW-1:0]    tol,
  output logic                        found,
  output sgi_pkg::job_t               job_x,
  output sgi_pkg::job_t               job_y
);

  function automatic logic [sgi_pkg::DW-1:0] abs_d(input logic signed [sgi_pkg::DW-1:0] v);
    return v[sgi_pkg::DW-1] ? sgi_pkg::DW'(-v) : sgi_pkg::DW'(v);
  endfunction

  logic signed [sgi_pkg::DW-1:0] s1_dxa_r, s1_dya_r, s1_dxb_r, s1_dyb_r, s1_ex_r, s1_ey_r;
  logic signed [sgi_pkg::CW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r;
  logic [sgi_pkg::TOLW-1:0]      s1_tol_r, s1_tol_nxt;

  assign s1_tol_nxt = (tol == '0) ? sgi_pkg::TOLW'(1) : tol;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dxa_r <= sgi_pkg::DW'(seg.seg1_x_end) - sgi_pkg::DW'(seg.seg1_x_start);
      s1_dya_r <= sgi_pkg::DW'(seg.seg1_y_end) - sgi_pkg::DW'(seg.seg1_y_start);
      s1_dxb_r <= sgi_pkg::DW'(seg.seg2_x_end) - sgi_pkg::DW'(seg.seg2_x_start);
      s1_dyb_r <= sgi_pkg::DW'(seg.seg2_y_end) - sgi_pkg::DW'(seg.seg2_y_start);
      s1_ex_r  <= sgi_pkg::DW'(seg.seg2_x_start) - sgi_pkg::DW'(seg.seg1_x_start);
      s1_ey_r  <= sgi_pkg::DW'(seg.seg2_y_start) - sgi_pkg::DW'(seg.seg1_y_start);
      s1_ax_r  <= seg.seg1_x_start;
      s1_ay_r  <= seg.seg1_y_start;
      s1_bx_r  <= seg.seg2_x_start;
      s1_by_r  <= seg.seg2_y_start;
      s1_tol_r <= s1_tol_nxt;
    end
  end

  logic [sgi_pkg::DW-1:0]          ab_dxa, ab_dxb;
  logic signed [sgi_pkg::PW-1:0]   s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r, s2_p5_r;
  logic [sgi_pkg::TOLW+sgi_pkg::DW-1:0] s2_ta_r, s2_tb_r;
  logic                            s2_va_r, s2_vb_r;
  logic [sgi_pkg::DW-1:0]          s2_adya_r, s2_adyb_r;
  logic signed [sgi_pkg::DW-1:0]   s2_dxa_r, s2_dya_r, s2_dxb_r, s2_dyb_r, s2_ex_r, s2_ey_r;
  logic signed [sgi_pkg::CW-1:0]   s2_ax_r, s2_ay_r, s2_bx_r, s2_by_r;
  logic [sgi_pkg::TOLW-1:0]        s2_tol_r;

  assign ab_dxa = abs_d(s1_dxa_r);
  assign ab_dxb = abs_d(s1_dxb_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p1_r   <= s1_dya_r * s1_dxb_r;
      s2_p2_r   <= s1_dyb_r * s1_dxa_r;
      s2_p3_r   <= s1_dxa_r * s1_dxb_r;
      s2_p4_r   <= s1_ex_r * s1_dyb_r;
      s2_p5_r   <= s1_ey_r * s1_dxb_r;
      s2_ta_r   <= s1_tol_r * ab_dxa;
      s2_tb_r   <= s1_tol_r * ab_dxb;
      s2_va_r   <= ab_dxa < sgi_pkg::DW'(s1_tol_r);
      s2_vb_r   <= ab_dxb < sgi_pkg::DW'(s1_tol_r);
      s2_adya_r <= abs_d(s1_dya_r);
      s2_adyb_r <= abs_d(s1_dyb_r);
      s2_dxa_r  <= s1_dxa_r;
      s2_dya_r  <= s1_dya_r;
      s2_dxb_r  <= s1_dxb_r;
      s2_dyb_r  <= s1_dyb_r;
      s2_ex_r   <= s1_ex_r;
      s2_ey_r   <= s1_ey_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
      s2_bx_r   <= s1_bx_r;
      s2_by_r   <= s1_by_r;
      s2_tol_r  <= s1_tol_r;
    end
  end

  logic [sgi_pkg::PW-1:0]          ab_p3;
  logic signed [sgi_pkg::WW-1:0]   s3_cr_r, s3_tn_r;
  logic [sgi_pkg::TOLW+sgi_pkg::DW-1:0]   s3_rl_r;
  logic [sgi_pkg::TOLW+sgi_pkg::PW-2-sgi_pkg::DW:0] s3_rh_r;
  logic                            s3_sa_r, s3_sb_r, s3_va_r, s3_vb_r;
  logic signed [sgi_pkg::DW-1:0]   s3_dxa_r, s3_dya_r, s3_dxb_r, s3_dyb_r, s3_ex_r, s3_ey_r;
  logic signed [sgi_pkg::CW-1:0]   s3_ax_r, s3_ay_r, s3_bx_r, s3_by_r;

  assign ab_p3 = s2_p3_r[sgi_pkg::PW-1] ? sgi_pkg::PW'(-s2_p3_r) : sgi_pkg::PW'(s2_p3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cr_r  <= sgi_pkg::WW'(s2_p1_r) - sgi_pkg::WW'(s2_p2_r);
      s3_tn_r  <= sgi_pkg::WW'(s2_p4_r) - sgi_pkg::WW'(s2_p5_r);
      s3_rl_r  <= s2_tol_r * ab_p3[sgi_pkg::DW-1:0];
      s3_rh_r  <= s2_tol_r * ab_p3[sgi_pkg::PW-2:sgi_pkg::DW];
      s3_sa_r  <= (sgi_pkg::SLW'(s2_adya_r) << sgi_pkg::COORD_FRAC_BITS) <
                  sgi_pkg::SLW'(s2_ta_r);
      s3_sb_r  <= (sgi_pkg::SLW'(s2_adyb_r) << sgi_pkg::COORD_FRAC_BITS) <
                  sgi_pkg::SLW'(s2_tb_r);
      s3_va_r  <= s2_va_r;
      s3_vb_r  <= s2_vb_r;
      s3_dxa_r <= s2_dxa_r;
      s3_dya_r <= s2_dya_r;
      s3_dxb_r <= s2_dxb_r;
      s3_dyb_r <= s2_dyb_r;
      s3_ex_r  <= s2_ex_r;
      s3_ey_r  <= s2_ey_r;
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_bx_r  <= s2_bx_r;
      s3_by_r  <= s2_by_r;
    end
  end

  logic [sgi_pkg::WW-1:0]  ab_cr;
  logic [sgi_pkg::PLW-1:0] lhs, rhs;
  logic                    par;
  logic                    found_nxt;
  sgi_pkg::job_t           jx_nxt, jy_nxt;
  logic                    found_r;
  sgi_pkg::job_t           jx_r, jy_r;

  assign ab_cr = s3_cr_r[sgi_pkg::WW-1] ? sgi_pkg::WW'(-s3_cr_r) : sgi_pkg::WW'(s3_cr_r);
  assign lhs   = sgi_pkg::PLW'(ab_cr) << sgi_pkg::COORD_FRAC_BITS;
  assign rhs   = (sgi_pkg::PLW'(s3_rh_r) << sgi_pkg::DW) + sgi_pkg::PLW'(s3_rl_r);
  assign par   = lhs < rhs;

  always_comb begin
    found_nxt      = 1'b1;
    jx_nxt         = '0;
    jy_nxt         = '0;
    jx_nxt.direct  = sgi_pkg::SENTINEL;
    jy_nxt.direct  = sgi_pkg::SENTINEL;
    if (s3_va_r) begin
      if (s3_vb_r) begin
        found_nxt = 1'b0;
      end else begin
        jx_nxt.direct  = s3_ax_r;
        jy_nxt.compute = 1'b1;
        jy_nxt.base    = s3_by_r;
        jy_nxt.p       = s3_dyb_r;
        jy_nxt.q       = -sgi_pkg::WW'(s3_ex_r);
        jy_nxt.den     = sgi_pkg::WW'(s3_dxb_r);
      end
    end else if (s3_vb_r) begin
      jx_nxt.direct  = s3_bx_r;
      jy_nxt.compute = 1'b1;
      jy_nxt.base    = s3_ay_r;
      jy_nxt.p       = s3_dya_r;
      jy_nxt.q       = sgi_pkg::WW'(s3_ex_r);
      jy_nxt.den     = sgi_pkg::WW'(s3_dxa_r);
    end else if (par) begin
      found_nxt = 1'b0;
    end else if (s3_sa_r) begin
      jy_nxt.direct  = s3_ay_r;
      jx_nxt.compute = 1'b1;
      jx_nxt.base    = s3_bx_r;
      jx_nxt.p       = s3_dxb_r;
      jx_nxt.q       = -sgi_pkg::WW'(s3_ey_r);
      jx_nxt.den     = sgi_pkg::WW'(s3_dyb_r);
    end else if (s3_sb_r) begin
      jy_nxt.direct  = s3_by_r;
      jx_nxt.compute = 1'b1;
      jx_nxt.base    = s3_ax_r;
      jx_nxt.p       = s3_dxa_r;
      jx_nxt.q       = sgi_pkg::WW'(s3_ey_r);
      jx_nxt.den     = sgi_pkg::WW'(s3_dya_r);
    end else begin
      jx_nxt.compute = 1'b1;
      jx_nxt.base    = s3_ax_r;
      jx_nxt.p       = s3_dxa_r;
      jx_nxt.q       = s3_tn_r;
      jx_nxt.den     = -s3_cr_r;
      jy_nxt.compute = 1'b1;
      jy_nxt.base    = s3_ay_r;
      jy_nxt.p       = s3_dya_r;
      jy_nxt.q       = s3_tn_r;
      jy_nxt.den     = -s3_cr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      found_r <= found_nxt;
      jx_r    <= jx_nxt;
      jy_r    <= jy_nxt;
    end
  end

  assign found = found_r;
  assign job_x = jx_r;
  assign job_y = jy_r;

endmodule

@@ hdl/sgi_resolve.sv @@
// Coordinate pipeline: base plus numerator over denominator, restoring division, rounding, saturation.
module sgi_resolve (
  input  logic          clk,
  input  logic          en,
  input  sgi_pkg::job_t job,
  output sgi_pkg::res_t res
);

  typedef struct packed {
    logic          fix;
    logic          neg;
    logic [sgi_pkg::CW-1:0] fixval;
  } ctl_t;

  logic signed [sgi_pkg::DW+sgi_pkg::WW-sgi_pkg::SPL-1:0] pp_hi_r;
  logic signed [sgi_pkg::DW+sgi_pkg::SPL:0]               pp_lo_r;
  logic signed [sgi_pkg::CW+sgi_pkg::WW-sgi_pkg::SPL-1:0] bd_hi_r;
  logic signed [sgi_pkg::CW+sgi_pkg::SPL:0]               bd_lo_r;
  sgi_pkg::job_t                                          j1_r, j2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_hi_r <= job.p * $signed(job.q[sgi_pkg::WW-1:sgi_pkg::SPL]);
      pp_lo_r <= job.p * $signed({1'b0, job.q[sgi_pkg::SPL-1:0]});
      bd_hi_r <= job.base * $signed(job.den[sgi_pkg::WW-1:sgi_pkg::SPL]);
      bd_lo_r <= job.base * $signed({1'b0, job.den[sgi_pkg::SPL-1:0]});
      j1_r    <= job;
    end
  end

  logic signed [sgi_pkg::TW-1:0] num_r, bd_r, tot_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= (sgi_pkg::TW'(pp_hi_r) <<< sgi_pkg::SPL) + sgi_pkg::TW'(pp_lo_r);
      bd_r  <= (sgi_pkg::TW'(bd_hi_r) <<< sgi_pkg::SPL) + sgi_pkg::TW'(bd_lo_r);
      j2_r  <= j1_r;
    end
  end

  logic signed [sgi_pkg::TW-1:0] tot_r;
  logic signed [sgi_pkg::WW-1:0] den3_r;
  ctl_t                          ctl3_r, ctl3_nxt;

  assign tot_nxt = bd_r + num_r;

  always_comb begin
    ctl3_nxt.fix    = !j2_r.compute || (j2_r.den == '0);
    ctl3_nxt.neg    = tot_nxt[sgi_pkg::TW-1] ^ j2_r.den[sgi_pkg::WW-1];
    ctl3_nxt.fixval = j2_r.compute ? j2_r.base : j2_r.direct;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot_r  <= tot_nxt;
      den3_r <= j2_r.den;
      ctl3_r <= ctl3_nxt;
    end
  end

  logic [sgi_pkg::TW-1:0] mag_r;
  logic [sgi_pkg::WW-1:0] dm4_r;
  ctl_t                   ctl4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= tot_r[sgi_pkg::TW-1] ? sgi_pkg::TW'(-tot_r) : sgi_pkg::TW'(tot_r);
      dm4_r  <= den3_r[sgi_pkg::WW-1] ? sgi_pkg::WW'(-den3_r) : sgi_pkg::WW'(den3_r);
      ctl4_r <= ctl3_r;
    end
  end

  logic [sgi_pkg::TW-1:0] rem_w [0:sgi_pkg::QB];
  logic [sgi_pkg::QB-1:0] quo_w [0:sgi_pkg::QB];
  logic [sgi_pkg::WW-1:0] dm_w  [0:sgi_pkg::QB];
  logic                   big_w [0:sgi_pkg::QB];
  ctl_t                   ctl_w [0:sgi_pkg::QB];

  logic [sgi_pkg::TW-1:0] rem_r [0:sgi_pkg::QB-1];
  logic [sgi_pkg::QB-1:0] quo_r [0:sgi_pkg::QB-1];
  logic [sgi_pkg::WW-1:0] dm_r  [0:sgi_pkg::QB-1];
  logic                   big_r [0:sgi_pkg::QB-1];
  ctl_t                   ctl_r [0:sgi_pkg::QB-1];

  assign rem_w[0] = mag_r;
  assign quo_w[0] = '0;
  assign dm_w[0]  = dm4_r;
  assign big_w[0] = mag_r >= (sgi_pkg::TW'(dm4_r) << sgi_pkg::QB);
  assign ctl_w[0] = ctl4_r;

  for (genvar k = 0; k < sgi_pkg::QB; k++) begin : g_div
    logic [sgi_pkg::TW-1:0] sh;
    logic                   ge;
    logic [sgi_pkg::TW-1:0] rem_nxt;

    assign sh      = sgi_pkg::TW'(dm_w[k]) << (sgi_pkg::QB - 1 - k);
    assign ge      = rem_w[k] >= sh;
    assign rem_nxt = ge ? rem_w[k] - sh : rem_w[k];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        quo_r[k] <= {quo_w[k][sgi_pkg::QB-2:0], ge};
        dm_r[k]  <= dm_w[k];
        big_r[k] <= big_w[k];
        ctl_r[k] <= ctl_w[k];
      end
    end

    assign rem_w[k+1] = rem_r[k];
    assign quo_w[k+1] = quo_r[k];
    assign dm_w[k+1]  = dm_r[k];
    assign big_w[k+1] = big_r[k];
    assign ctl_w[k+1] = ctl_r[k];
  end

  logic                   rnd;
  logic [sgi_pkg::QB:0]   qr_r;
  logic                   bigq_r;
  ctl_t                   ctlq_r;

  assign rnd = {rem_w[sgi_pkg::QB][sgi_pkg::WW-1:0], 1'b0} >= {1'b0, dm_w[sgi_pkg::QB]};

  always_ff @(posedge clk) begin
    if (en) begin
      qr_r   <= {1'b0, quo_w[sgi_pkg::QB]} + (sgi_pkg::QB+1)'(rnd);
      bigq_r <= big_w[sgi_pkg::QB];
      ctlq_r <= ctl_w[sgi_pkg::QB];
    end
  end

  logic [sgi_pkg::QB:0]   lim;
  logic                   sat;
  sgi_pkg::res_t          res_nxt, res_r;

  assign lim = ctlq_r.neg ? ((sgi_pkg::QB+1)'(1) << (sgi_pkg::CW-1)) :
                            (((sgi_pkg::QB+1)'(1) << (sgi_pkg::CW-1)) - (sgi_pkg::QB+1)'(1));
  assign sat = bigq_r || (qr_r > lim);

  always_comb begin
    res_nxt.ovf = 1'b0;
    if (ctlq_r.fix) begin
      res_nxt.value = ctlq_r.fixval;
    end else if (sat) begin
      res_nxt.ovf   = 1'b1;
      res_nxt.value = ctlq_r.neg ? {1'b1, {(sgi_pkg::CW-1){1'b0}}} :
                                   {1'b0, {(sgi_pkg::CW-1){1'b1}}};
    end else begin
      res_nxt.value = ctlq_r.neg ? -qr_r[sgi_pkg::CW-1:0] : qr_r[sgi_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ hdl/segment_intersection.sv @@
// Top level of the segment intersection pipeline.
//
//   Channel  Direction  Handshake          Payload
//   in       input      in_valid/in_stall   two segments, eight Q16.16 coordinates
//   out      output     out_valid/out_stall point, found, within and overflow flags
//   cfg      input      cfg_wr_en           equal tolerance, 16 bits
//
// Most of the pipeline depth lies in the 34 one-bit stages of the divider.
// A new item is accepted in every cycle while the output is not held.
// The whole pipeline holds while a result waits at the output and out_stall is high.
// Reset clears the valid bits and sets the tolerance to one.
module segment_intersection (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_seg1_x_start,
  input  logic signed [31:0]  in_seg1_y_start,
  input  logic signed [31:0]  in_seg1_x_end,
  input  logic signed [31:0]  in_seg1_y_end,
  input  logic signed [31:0]  in_seg2_x_start,
  input  logic signed [31:0]  in_seg2_y_start,
  input  logic signed [31:0]  in_seg2_x_end,
  input  logic signed [31:0]  in_seg2_y_end,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_cross_x,
  output logic signed [31:0]  out_cross_y,
  output logic                out_point_found,
  output logic                out_within_both,
  output logic                out_overflowed,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  function automatic logic in_span(input logic signed [31:0] v,
                                   input logic signed [31:0] a,
                                   input logic signed [31:0] b);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (v >= lo) && (v <= hi);
  endfunction

  logic                     en;
  logic [15:0]              tol_r;
  sgi_pkg::seg_t            seg_in;
  logic                     found;
  sgi_pkg::job_t            job_x, job_y;
  sgi_pkg::res_t            res_x, res_y;

  logic                     vld_r [0:sgi_pkg::PIPE_LAT-1];
  sgi_pkg::seg_t            seg_r [0:sgi_pkg::PIPE_LAT-1];
  logic                     fnd_r [0:sgi_pkg::RES_LAT-1];

  logic                     out_valid_r;
  logic signed [31:0]       cross_x_r, cross_y_r;
  logic                     found_r, within_r, ovf_r;
  logic                     within_nxt;
  sgi_pkg::seg_t            seg_end;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_comb begin
    seg_in.seg1_x_start = in_seg1_x_start;
    seg_in.seg1_y_start = in_seg1_y_start;
    seg_in.seg1_x_end   = in_seg1_x_end;
    seg_in.seg1_y_end   = in_seg1_y_end;
    seg_in.seg2_x_start = in_seg2_x_start;
    seg_in.seg2_y_start = in_seg2_y_start;
    seg_in.seg2_x_end   = in_seg2_x_end;
    seg_in.seg2_y_end   = in_seg2_y_end;
  end

  sgi_front u_front (
    .clk   (clk),
    .en    (en),
    .seg   (seg_in),
    .tol   (tol_r),
    .found (found),
    .job_x (job_x),
    .job_y (job_y)
  );

  sgi_resolve u_res_x (
    .clk (clk),
    .en  (en),
    .job (job_x),
    .res (res_x)
  );

  sgi_resolve u_res_y (
    .clk (clk),
    .en  (en),
    .job (job_y),
    .res (res_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sgi_pkg::PIPE_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < sgi_pkg::PIPE_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_r[0] <= seg_in;
      for (int i = 1; i < sgi_pkg::PIPE_LAT; i++) begin
        seg_r[i] <= seg_r[i-1];
      end
      fnd_r[0] <= found;
      for (int i = 1; i < sgi_pkg::RES_LAT; i++) begin
        fnd_r[i] <= fnd_r[i-1];
      end
    end
  end

  assign seg_end = seg_r[sgi_pkg::PIPE_LAT-1];

  assign within_nxt = fnd_r[sgi_pkg::RES_LAT-1] &&
    in_span(res_x.value, seg_end.seg1_x_start, seg_end.seg1_x_end) &&
    in_span(res_x.value, seg_end.seg2_x_start, seg_end.seg2_x_end) &&
    in_span(res_y.value, seg_end.seg1_y_start, seg_end.seg1_y_end) &&
    in_span(res_y.value, seg_end.seg2_y_start, seg_end.seg2_y_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[sgi_pkg::PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross_x_r <= res_x.value;
      cross_y_r <= res_y.value;
      found_r   <= fnd_r[sgi_pkg::RES_LAT-1];
      within_r  <= within_nxt;
      ovf_r     <= res_x.ovf || res_y.ovf;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cross_x     = cross_x_r;
  assign out_cross_y     = cross_y_r;
  assign out_point_found = found_r;
  assign out_within_both = within_r;
  assign out_overflowed  = ovf_r;

endmodule

@@ hdl/sgi_checker.sv @@
// Port checker for the segment intersection top level, with its bind.
module sgi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_cross_x,
  input logic signed [31:0] out_cross_y,
  input logic               out_point_found,
  input logic               out_within_both,
  input logic               out_overflowed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cross_x) && $stable(out_cross_y))
    else $error("result item changed while stalled");

  a_no_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_found |-> out_cross_x == sgi_pkg::SENTINEL &&
      out_cross_y == sgi_pkg::SENTINEL && !out_within_both && !out_overflowed)
    else $error("missing point not reported as the sentinel");

  a_within_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_within_both |-> out_point_found)
    else $error("within set without a point");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input held without a held result");

endmodule

bind segment_intersection sgi_checker u_sgi_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the segment intersection pipeline, with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    bit          found;
    bit          in_bounds;
    bit          ovf;
  } point_t;

  class crossing_board;
    point_t      pending_q[$];
    int          errors;
    logic [15:0] tol;

    function new();
      errors = 0;
      tol = 16'd1;
    endfunction

    function automatic logic [31:0] round_div(wide_t base, wide_t num, wide_t den,
                                              inout bit ovf);
      wide_t tot, mag, dm, q, r, lim;
      bit    neg;
      if (den == 0) return base[31:0];
      tot = base * den + num;
      neg = (tot < 0) != (den < 0);
      mag = (tot < 0) ? -tot : tot;
      dm  = (den < 0) ? -den : den;
      q = mag / dm;
      r = mag % dm;
      if (2 * r >= dm) q = q + 1;
      lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
      if (q > lim) begin
        ovf = 1;
        return neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end
      return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic bit between(wide_t v, wide_t a, wide_t b);
      return (a < b) ? (v >= a && v <= b) : (v >= b && v <= a);
    endfunction

    function automatic void note(sgi_pkg::seg_t s);
      wide_t  ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      wide_t  dxa, dya, dxb, dyb, t, cr, tn, xs, ys;
      point_t p;
      ax0 = s.seg1_x_start; ay0 = s.seg1_y_start; ax1 = s.seg1_x_end; ay1 = s.seg1_y_end;
      bx0 = s.seg2_x_start; by0 = s.seg2_y_start; bx1 = s.seg2_x_end; by1 = s.seg2_y_end;
      dxa = ax1 - ax0; dya = ay1 - ay0; dxb = bx1 - bx0; dyb = by1 - by0;
      t = (tol == 0) ? wide_t'(1) : wide_t'(tol);
      p.found = 1;
      p.ovf = 0;
      p.x = 0;
      p.y = 0;
      if ((dxa < 0 ? -dxa : dxa) < t) begin
        if ((dxb < 0 ? -dxb : dxb) < t) p.found = 0;
        else begin
          p.x = ax0[31:0];
          p.y = round_div(by0, dyb * (ax0 - bx0), dxb, p.ovf);
        end
      end else if ((dxb < 0 ? -dxb : dxb) < t) begin
        p.x = bx0[31:0];
        p.y = round_div(ay0, dya * (bx0 - ax0), dxa, p.ovf);
      end else begin
        cr = dya * dxb - dyb * dxa;
        if (((cr < 0 ? -cr : cr) <<< sgi_pkg::COORD_FRAC_BITS) <
            t * ((dxa * dxb < 0) ? -(dxa * dxb) : dxa * dxb))
          p.found = 0;
        else if (((dya < 0 ? -dya : dya) <<< sgi_pkg::COORD_FRAC_BITS) <
                 t * (dxa < 0 ? -dxa : dxa)) begin
          p.y = ay0[31:0];
          p.x = round_div(bx0, (ay0 - by0) * dxb, dyb, p.ovf);
        end else if (((dyb < 0 ? -dyb : dyb) <<< sgi_pkg::COORD_FRAC_BITS) <
                     t * (dxb < 0 ? -dxb : dxb)) begin
          p.y = by0[31:0];
          p.x = round_div(ax0, (by0 - ay0) * dxa, dya, p.ovf);
        end else begin
          tn = (bx0 - ax0) * dyb - (by0 - ay0) * dxb;
          p.x = round_div(ax0, dxa * tn, -cr, p.ovf);
          p.y = round_div(ay0, dya * tn, -cr, p.ovf);
        end
      end
      if (!p.found) begin
        p.x = sgi_pkg::SENTINEL;
        p.y = sgi_pkg::SENTINEL;
        p.ovf = 0;
        p.in_bounds = 0;
      end else begin
        xs = wide_t'($signed(p.x));
        ys = wide_t'($signed(p.y));
        p.in_bounds = between(xs, ax0, ax1) && between(xs, bx0, bx1) &&
                      between(ys, ay0, ay1) && between(ys, by0, by1);
      end
      pending_q.push_back(p);
    endfunction

    function automatic void check(point_t got);
      point_t e;
      if (pending_q.size() == 0) begin
        $error("Result item arrived with no item outstanding.");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.x !== e.x) begin
        $error("cross_x: expected %h, got %h", e.x, got.x); errors++;
      end
      if (got.y !== e.y) begin
        $error("cross_y: expected %h, got %h", e.y, got.y); errors++;
      end
      if (got.found !== e.found) begin
        $error("point_found: expected %0d, got %0d", e.found, got.found); errors++;
      end
      if (got.in_bounds !== e.in_bounds) begin
        $error("within_both: expected %0d, got %0d", e.in_bounds, got.in_bounds); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflowed: expected %0d, got %0d", e.ovf, got.ovf); errors++;
      end
    endfunction
  endclass

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0;
  logic          in_stall;
  sgi_pkg::seg_t drv = '0;
  logic          out_valid;
  logic          out_stall = 0;
  logic [31:0]   out_cross_x, out_cross_y;
  logic          out_point_found, out_within_both, out_overflowed;
  logic          cfg_wr_en = 0;
  logic [15:0]   cfg_wr_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  crossing_board board = new();

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  segment_intersection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_seg1_x_start(drv.seg1_x_start), .in_seg1_y_start(drv.seg1_y_start),
    .in_seg1_x_end(drv.seg1_x_end), .in_seg1_y_end(drv.seg1_y_end),
    .in_seg2_x_start(drv.seg2_x_start), .in_seg2_y_start(drv.seg2_y_start),
    .in_seg2_x_end(drv.seg2_x_end), .in_seg2_y_end(drv.seg2_y_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y),
    .out_point_found(out_point_found), .out_within_both(out_within_both),
    .out_overflowed(out_overflowed),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    point_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) board.note(drv);
      if (out_valid && !out_stall) begin
        got.x = out_cross_x;
        got.y = out_cross_y;
        got.found = out_point_found;
        got.in_bounds = out_within_both;
        got.ovf = out_overflowed;
        board.check(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] near(logic [31:0] v);
    return v + $urandom_range(0, 1 << 20) - (1 << 19);
  endfunction

  function automatic sgi_pkg::seg_t make_pair();
    sgi_pkg::seg_t s;
    int   mode;
    int   k;
    mode = $urandom_range(0, 11);
    s.seg1_x_start = near(0); s.seg1_y_start = near(0);
    s.seg1_x_end = near(0);   s.seg1_y_end = near(0);
    s.seg2_x_start = near(0); s.seg2_y_start = near(0);
    s.seg2_x_end = near(0);   s.seg2_y_end = near(0);
    case (mode)
      0, 1: begin
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      end
      2: s.seg1_x_end = s.seg1_x_start + $urandom_range(0, 2) - 1;
      3: s.seg2_x_end = s.seg2_x_start + $urandom_range(0, 2) - 1;
      4: begin
        s.seg1_x_end = s.seg1_x_start;
        s.seg2_x_end = s.seg2_x_start + $urandom_range(0, 2);
      end
      5: begin
        k = $urandom_range(1, 3);
        s.seg2_x_end = s.seg2_x_start + k * (s.seg1_x_end - s.seg1_x_start);
        s.seg2_y_end = s.seg2_y_start + k * (s.seg1_y_end - s.seg1_y_start)
                       + $urandom_range(0, 2) - 1;
      end
      6: s.seg1_y_end = s.seg1_y_start + $urandom_range(0, 4) - 2;
      7: s.seg2_y_end = s.seg2_y_start + $urandom_range(0, 4) - 2;
      8: begin
        s.seg1_x_start = $urandom; s.seg1_y_start = $urandom;
        s.seg2_x_start = $urandom; s.seg2_y_start = $urandom;
        s.seg1_x_end = s.seg1_x_start + $urandom_range(1, 4000);
        s.seg1_y_end = s.seg1_y_start + $urandom_range(1, 4000);
        s.seg2_x_end = s.seg2_x_start + $urandom_range(1, 4000);
        s.seg2_y_end = s.seg2_y_start + $urandom_range(1, 4000);
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_pair(sgi_pkg::seg_t s);
    if ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    drv = s;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [15:0] v);
    in_valid = 0;
    wait (board.pending_q.size() == 0);
    repeat (sgi_pkg::PIPE_LAT + 8) @(negedge clk);
    cfg_wr_en = 1;
    cfg_wr_data = v;
    board.tol = v;
    @(negedge clk);
    cfg_wr_en = 0;
  endtask

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SNT  = sgi_pkg::SENTINEL;

  initial begin
    int            idle_set[4]  = '{0, 49, 0, 36};
    int            stall_set[4] = '{0, 0, 49, 36};
    logic [15:0]   tol_set[6]   = '{16'd0, 16'hffff, 16'd1, 16'd256, 16'h5a5a, 16'd7};
    sgi_pkg::seg_t directed[$];
    repeat (8) @(negedge clk);
    rst_n = 1;

    directed.push_back({MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
    directed.push_back({MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC});
    directed.push_back({MINC, MINC, MINC, MINC, MAXC, MINC, MINC, MAXC});
    directed.push_back({ONE, 32'd0, ONE, ONE, 32'd0, 32'd0, 2 * ONE, ONE});
    directed.push_back({32'd0, 32'd0, 2 * ONE, ONE, ONE, 32'd0, ONE, 2 * ONE});
    directed.push_back({ONE, 32'd0, ONE, ONE, 2 * ONE, 32'd0, 2 * ONE, ONE});
    directed.push_back({32'd0, 32'd0, ONE, ONE, 32'd0, ONE, ONE, 2 * ONE});
    directed.push_back({32'd0, ONE, 2 * ONE, ONE, ONE, 32'd0, 2 * ONE, 2 * ONE});
    directed.push_back({32'd0, 32'd0, ONE, 2 * ONE, 32'd0, ONE, 2 * ONE, ONE});
    directed.push_back({32'd0, 32'd0, 2 * ONE, 2 * ONE, 32'd0, 2 * ONE, 2 * ONE, 32'd0});
    directed.push_back({32'd0, 32'd0, 32'd3, 32'd1, 32'd0, 32'd1, 32'd3, 32'd2 + 32'd0});
    directed.push_back({32'd0, 32'd0, MAXC, 32'd1, 32'd0, 32'd2, MAXC, 32'd2 + 32'd1});
    directed.push_back({MINC, 32'd0, MAXC, 32'd3, MINC, 32'd1, MAXC, 32'd5});
    directed.push_back({SNT, 32'd0, SNT, ONE, 32'd0, SNT, ONE, SNT});
    directed.push_back({32'd0, 32'd0, 32'd3, 32'd0, 32'd1, 32'd1, 32'd2, 32'd3});
    directed.push_back({32'd1, 32'd1, 32'd4, 32'd2, 32'd0, 32'd5, 32'd4, 32'd3});
    foreach (directed[i]) send_pair(directed[i]);

    for (int t = 0; t < 6; t++) begin
      write_tolerance(tol_set[t]);
      for (int ph = 0; ph < 4; ph++) begin
        idle_pct = idle_set[ph];
        stall_pct = stall_set[ph];
        repeat (75) send_pair(make_pair());
      end
    end

    in_valid = 0;
    wait (board.pending_q.size() == 0);
    repeat (sgi_pkg::PIPE_LAT + 10) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
